### sv/lwcq_pkg.sv
// shared types and constants of the coalescing request queue
package lwcq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 64;
    localparam int DATA_W      = 200;
    localparam int KIND_W      = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUEUED    = 3'd0,
        KIND_CANCELLED = 3'd1,
        KIND_STALE     = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_POPPED    = 3'd4,
        KIND_EMPTY     = 3'd5
    } kind_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] order;
        logic [KEY_W-1:0] gesture;
        logic             drag;
        logic [KEY_W-1:0] id;
    } entry_t;

    typedef struct packed {
        logic cmp_en;
        logic take_next;
        logic take_new;
    } cell_ctrl_t;

    typedef struct packed {
        logic hit;
        logic older;
    } cell_flags_t;

endpackage

### sv/lwcq_cell.sv
// one queue slot: holds an entry, shifts from its neighbor, compares against a key
module lwcq_cell (
    input  logic                      aclk,
    input  lwcq_pkg::cell_ctrl_t      ctrl,
    input  lwcq_pkg::entry_t          new_entry,
    input  lwcq_pkg::entry_t          next_entry,
    input  logic [lwcq_pkg::KEY_W-1:0] key_gesture,
    input  logic [lwcq_pkg::KEY_W-1:0] key_order,
    output lwcq_pkg::entry_t          entry,
    output lwcq_pkg::cell_flags_t     flags
);
    import lwcq_pkg::*;

    entry_t      entry_reg;
    entry_t      entry_next;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.take_new) begin
            entry_next = new_entry;
        end else if (ctrl.take_next) begin
            entry_next = next_entry;
        end
    end

    always_comb begin
        flags_next = flags_reg;
        if (ctrl.cmp_en) begin
            flags_next.hit   = entry_reg.drag && (entry_reg.gesture == key_gesture);
            flags_next.older = entry_reg.order < key_order;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        flags_reg <= flags_next;
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

### sv/latest_wins_coalescing_queue.sv
// top level of the latest-wins coalescing request queue
//
// usage
// - input transactions on s_t*: s_tuser is the operation (0 push, 1 pop),
//   s_tdata carries the pushed request; on a pop s_tdata is ignored
// - every input transaction gives exactly one result transaction on m_t*:
//   m_tuser is the result kind, m_tdata the reported id and popped entry
// - each transaction has an accept cycle, in which every cell
//   registers its gesture match and sequence compare, and an execute state,
//   in which the first match is picked and the cell chain shifts or loads
// - the result is registered in the output register when the execute state
//   completes; a new transaction is accepted only after the previous one has executed
// - a stalled receiver holds the result in the output register; the next
//   transaction is still accepted and waits in execute until the result leaves
// - reset clears the fill count and the handshake state only; slot contents
//   stay undefined and are used only below the fill count
module latest_wins_coalescing_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic                         s_tuser,   // operation
    input  logic [lwcq_pkg::DATA_W-1:0]  s_tdata,   // request_id, drag_flag,
                                                    // gesture_key, drag_order, zero fill
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lwcq_pkg::KIND_W-1:0]  m_tuser,   // result_kind
    output logic [lwcq_pkg::DATA_W-1:0]  m_tdata    // reported_id, popped_drag,
                                                    // popped_gesture, popped_order, zero fill
);
    import lwcq_pkg::*;

    localparam int PAD_W = DATA_W - (3 * KEY_W + 1);

    // handshake state
    state_t state_reg;
    state_t state_next;
    logic   s_fire;
    logic   exec_fire;

    // latched request
    op_t    op_reg;
    op_t    op_next;
    entry_t req_reg;
    entry_t req_next;
    entry_t s_entry;

    // queue occupancy
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] last_idx;

    // output register
    logic              m_valid_reg;
    logic              m_valid_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // cell chain
    cell_ctrl_t  cell_ctrl [QUEUE_DEPTH];
    entry_t      cell_entry [QUEUE_DEPTH];
    entry_t      cell_next_in [QUEUE_DEPTH];
    cell_flags_t cell_flags [QUEUE_DEPTH];

    // search results
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic [QUEUE_DEPTH-1:0] older_vec;
    logic [QUEUE_DEPTH-1:0] first_vec;
    logic [QUEUE_DEPTH-1:0] upper_mask;
    logic                   any_hit;
    logic                   sel_older;
    logic [KEY_W-1:0]       sel_id;

    // decoded action of the execute cycle
    logic do_pop;
    logic do_cancel;
    logic do_append;

    assign s_entry.id      = s_tdata[KEY_W-1:0];
    assign s_entry.drag    = s_tdata[KEY_W];
    assign s_entry.gesture = s_tdata[2*KEY_W:KEY_W+1];
    assign s_entry.order   = s_tdata[3*KEY_W:2*KEY_W+1];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_EXEC: exec_fire = !m_valid_reg || m_tready;
            default: begin
                s_tready  = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    assign s_fire = s_tvalid && s_tready;

    // request latch
    always_comb begin
        op_next  = op_reg;
        req_next = req_reg;
        if (s_fire) begin
            op_next  = op_t'(s_tuser);
            req_next = s_entry;
        end
    end

    // match vectors, masked to occupied slots and to drag pushes
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            hit_vec[k]   = cell_flags[k].hit && (CNT_W'(k) < fill_reg) && req_reg.drag;
            older_vec[k] = cell_flags[k].older;
        end
    end

    // oldest match wins; slots from it upward shift down on a cancel
    assign first_vec  = hit_vec & (~hit_vec + QUEUE_DEPTH'(1));
    assign upper_mask = ~(first_vec - QUEUE_DEPTH'(1));
    assign any_hit    = |hit_vec;
    assign sel_older  = |(first_vec & older_vec);

    always_comb begin
        sel_id = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            sel_id = sel_id | (cell_entry[k].id & {KEY_W{first_vec[k]}});
        end
    end

    assign last_idx = fill_reg - CNT_W'(1);

    // decide the result and the queue update
    always_comb begin
        do_pop    = 1'b0;
        do_cancel = 1'b0;
        do_append = 1'b0;
        kind_next = kind_reg;
        data_next = data_reg;
        fill_next = fill_reg;
        if (exec_fire) begin
            data_next = '0;
            if (op_reg == OP_POP) begin
                if (fill_reg == '0) begin
                    kind_next = KIND_EMPTY;
                end else begin
                    do_pop    = 1'b1;
                    kind_next = KIND_POPPED;
                    data_next = {{PAD_W{1'b0}}, cell_entry[0].order, cell_entry[0].gesture,
                                 cell_entry[0].drag, cell_entry[0].id};
                    fill_next = fill_reg - CNT_W'(1);
                end
            end else if (any_hit) begin
                if (sel_older) begin
                    // older drag leaves, incoming drag goes to the tail
                    do_cancel              = 1'b1;
                    kind_next              = KIND_CANCELLED;
                    data_next[KEY_W-1:0]   = sel_id;
                end else begin
                    kind_next              = KIND_STALE;
                    data_next[KEY_W-1:0]   = req_reg.id;
                end
            end else if (fill_reg == CNT_W'(QUEUE_DEPTH)) begin
                kind_next = KIND_FULL;
            end else begin
                do_append = 1'b1;
                kind_next = KIND_QUEUED;
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // cell chain: each slot takes from the slot above or loads the request
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign cell_next_in[k] = req_reg;
        end else begin : g_body
            assign cell_next_in[k] = cell_entry[k+1];
        end

        always_comb begin
            cell_ctrl[k].cmp_en    = s_fire;
            cell_ctrl[k].take_next = do_pop || (do_cancel && upper_mask[k]);
            cell_ctrl[k].take_new  = (do_cancel && (CNT_W'(k) == last_idx))
                                  || (do_append && (CNT_W'(k) == fill_reg));
        end

        lwcq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[k]),
            .new_entry   (req_reg),
            .next_entry  (cell_next_in[k]),
            .key_gesture (s_entry.gesture),
            .key_order   (s_entry.order),
            .entry       (cell_entry[k]),
            .flags       (cell_flags[k])
        );
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        req_reg  <= req_next;
        kind_reg <= kind_next;
        data_reg <= data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = data_reg;

    // occupancy never passes the depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    // a queued push grows the queue by one
    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_append |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("append did not grow the queue");

    // a cancel replaces an entry and leaves occupancy unchanged
    a_cancel_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        do_cancel |=> $stable(fill_reg) && kind_reg == KIND_CANCELLED)
        else $error("cancel changed the fill count");

    // a pop only happens on a non-empty queue and shrinks it
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> fill_reg != '0 ##1 fill_reg == $past(fill_reg) - CNT_W'(1))
        else $error("pop did not shrink the queue");

    // the execute cycle never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |-> !m_valid_reg || m_tready)
        else $error("result overwritten while stalled");

endmodule
